FILE: rtl/core/integer_kth_root_assert.svh
// ---------------------------------------------------------------------------
// integer_kth_root_assert
// Assertion macros shared by the k-th root checker. Each macro takes a label,
// clock, active-low reset, antecedent and consequent.
// ---------------------------------------------------------------------------
`ifndef INTEGER_KTH_ROOT_ASSERT_SVH
`define INTEGER_KTH_ROOT_ASSERT_SVH

// Same-cycle implication.
`define IKR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_kth_root: same-cycle check failed");

// Next-cycle implication.
`define IKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_kth_root: next-cycle check failed");

`endif

FILE: rtl/core/ikr_pkg.sv
// ---------------------------------------------------------------------------
// ikr_pkg
// Shared widths and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ikr_pkg;

    localparam int VALUE_W = 63;
    localparam int EXP_W   = 6;
    localparam int ROOT_W  = 32;
    localparam int BIT_W   = 5;
    localparam int HALF_W  = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture operands, clear root
        logic trial;     // form next candidate, reset trial power
        logic mul_lo;    // low half of power times candidate
        logic mul_hi;    // high half of power times candidate
        logic accum;     // take the new power
        logic keep;      // candidate becomes the root
        logic next_bit;  // advance to the next lower root bit
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fits;      // power times candidate does not exceed the value
        logic last_mul;  // this multiply completes candidate^k
        logic bit_zero;  // working on root bit 0
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/integer_kth_root.sv
// Sequence: per root bit, one trial step, then per chained multiply of the
// candidate (1 to k, stopping at the first product past the value) a low-half
// multiply, a high-half multiply and a compare/accumulate step.
// Throughput: one item at a time; busy is high from the accepted beat until
// the strobe, which the receiver cannot stall.
// Reset: synchronous, active low; clears the sequencer, busy and the strobe.
// ---------------------------------------------------------------------------
// integer_kth_root
// Floor of the k-th root of a 63-bit value, built one root bit at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_kth_root #(
    parameter int VALUE_BITS = 63
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // command side: a beat is taken when start is high and busy is low
    input  wire                          start,
    output logic                         busy,
    input  wire [ikr_pkg::VALUE_W-1:0]   i_value,
    input  wire [ikr_pkg::EXP_W-1:0]     i_exponent,
    // result side: o_root is good for the single cycle o_valid is high
    output logic                         o_valid,
    output logic [ikr_pkg::ROOT_W-1:0]   o_root
);

    ikr_pkg::t_cmd w_cmd;
    ikr_pkg::t_sts w_sts;

    // The controller walks root bits 31 down to 0. For each bit it asks the
    // datapath to form candidate = root | bit, then repeats: low-half multiply,
    // high-half multiply, recombine and compare. A product above the value
    // drops the candidate at once, so the trial power never leaves 63 bits.
    ikr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Hold operands, candidate and power; share one 32x32 multiplier for
    // both halves of the 63-bit power.
    ikr_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_value    (i_value),
        .i_exponent (i_exponent),
        .o_sts      (w_sts),
        .o_root     (o_root)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ikr_dpath.sv
// ---------------------------------------------------------------------------
// ikr_dpath
// Root, candidate and trial-power registers around one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module ikr_dpath #(
    parameter int VALUE_BITS = 63
) (
    input  wire                          i_clk,
    input  wire ikr_pkg::t_cmd           i_cmd,
    input  wire [ikr_pkg::VALUE_W-1:0]   i_value,
    input  wire [ikr_pkg::EXP_W-1:0]     i_exponent,
    output ikr_pkg::t_sts                o_sts,
    output logic [ikr_pkg::ROOT_W-1:0]   o_root
);

    localparam int PROD_W = 2 * ikr_pkg::HALF_W;
    localparam int SUM_W  = 3 * ikr_pkg::HALF_W;

    logic [VALUE_BITS-1:0]          r_value;
    logic [ikr_pkg::EXP_W-1:0]      r_k;
    logic [ikr_pkg::ROOT_W-1:0]     r_root;
    logic [ikr_pkg::ROOT_W-1:0]     r_cand;
    logic [ikr_pkg::BIT_W-1:0]      r_bit;
    logic [VALUE_BITS-1:0]          r_pw;
    logic [ikr_pkg::EXP_W-1:0]      r_step;
    logic [PROD_W-1:0]              r_plo;
    logic [PROD_W-1:0]              r_phi;

    logic [PROD_W-1:0]              w_pw64;
    logic [ikr_pkg::HALF_W-1:0]     w_mul_a;
    logic [PROD_W-1:0]              w_prod;
    logic [SUM_W-1:0]               w_sum;

    assign w_pw64  = PROD_W'(r_pw);
    assign w_mul_a = i_cmd.mul_hi ? w_pw64[PROD_W-1:ikr_pkg::HALF_W]
                                  : w_pw64[ikr_pkg::HALF_W-1:0];
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(r_cand);

    // recombine the two partial products and compare against the radicand
    assign w_sum = {r_phi, {ikr_pkg::HALF_W{1'b0}}} + SUM_W'(r_plo);

    always_comb begin
        o_sts.fits     = (w_sum <= SUM_W'(r_value));
        o_sts.last_mul = (r_step == (r_k - ikr_pkg::EXP_W'(1)));
        o_sts.bit_zero = (r_bit == '0);
    end

    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value[VALUE_BITS-1:0];
            // exponent zero behaves as exponent one
            r_k     <= (i_exponent == '0) ? ikr_pkg::EXP_W'(1) : i_exponent;
            r_root  <= '0;
            r_bit   <= '1;
        end
        if (i_cmd.trial) begin
            r_cand <= r_root | (ikr_pkg::ROOT_W'(1) << r_bit);
            r_pw   <= VALUE_BITS'(1);
            r_step <= '0;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= w_prod;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_prod;
        end
        if (i_cmd.accum) begin
            r_pw   <= w_sum[VALUE_BITS-1:0];
            r_step <= r_step + ikr_pkg::EXP_W'(1);
        end
        if (i_cmd.keep) begin
            r_root <= r_cand;
        end
        if (i_cmd.next_bit) begin
            r_bit <= r_bit - ikr_pkg::BIT_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ikr_ctrl.sv
// ---------------------------------------------------------------------------
// ikr_ctrl
// Sequencer: per root bit, chain up to k multiplies, stop once past the value.
// ---------------------------------------------------------------------------
`default_nettype none

module ikr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire ikr_pkg::t_sts  i_sts,
    output ikr_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIAL,
        S_MLO,
        S_MHI,
        S_ACC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;
    logic   w_done_bit;

    // candidate settled: rejected, or its full power fits
    assign w_done_bit = !i_sts.fits || i_sts.last_mul;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.trial    = (r_state == S_TRIAL);
        o_cmd.mul_lo   = (r_state == S_MLO);
        o_cmd.mul_hi   = (r_state == S_MHI);
        o_cmd.accum    = (r_state == S_ACC) && i_sts.fits;
        o_cmd.keep     = (r_state == S_ACC) && i_sts.fits && i_sts.last_mul;
        o_cmd.next_bit = (r_state == S_ACC) && w_done_bit && !i_sts.bit_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_TRIAL;
                        r_busy  <= 1'b1;
                    end
                end
                S_TRIAL: r_state <= S_MLO;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_ACC;
                S_ACC: begin
                    priority if (!w_done_bit) begin
                        r_state <= S_MLO;
                    end else if (i_sts.bit_zero) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_TRIAL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: rtl/core/ikr_checker.sv
// ---------------------------------------------------------------------------
// ikr_checker
// Port-level checks of the command handshake and result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_kth_root_assert.svh"

module ikr_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_start,
    input wire i_busy,
    input wire i_valid
);

    // an accepted beat raises busy on the next cycle
    `IKR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    // the strobe lasts a single cycle
    `IKR_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, i_valid, !i_valid)
    // busy only drops together with a result
    `IKR_ASSERT_NEXT(a_busy_drop, i_clk, i_rst_n, i_busy, i_busy || i_valid)
    // a result follows a busy cycle and ends it
    `IKR_ASSERT_NOW(a_valid_after_busy, i_clk, i_rst_n, i_valid, !i_busy && $past(i_busy))

endmodule

bind integer_kth_root ikr_checker u_ikr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid)
);

`default_nettype wire

FILE: tb/sv/integer_kth_root_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_kth_root_checker
// Watches the command and result ports of the k-th root block, works out the
// floor root of every accepted beat and compares it with the returned root.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_kth_root_checker #(
    parameter int VALUE_BITS = 63
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire [ikr_pkg::VALUE_W-1:0]   i_value,
    input  wire [ikr_pkg::EXP_W-1:0]     i_exponent,
    input  wire                          o_valid,
    input  wire [ikr_pkg::ROOT_W-1:0]    o_root,
    output int                           root_failures,
    output int                           pending_roots
);

    typedef struct {
        logic [ikr_pkg::VALUE_W-1:0] value;
        logic [ikr_pkg::EXP_W-1:0]   exponent;
        logic [ikr_pkg::ROOT_W-1:0]  root;
    } root_query_t;

    localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;

    root_query_t root_queue[$];

    // Build the root from the top bit down; keep a candidate when its power,
    // formed by chained multiplies that stop once past the value, still fits.
    function automatic logic [ikr_pkg::ROOT_W-1:0] kth_root_floor(
        input logic [ikr_pkg::VALUE_W-1:0] radicand,
        input logic [ikr_pkg::EXP_W-1:0]   degree
    );
        logic [63:0] limit;
        logic [63:0] acc;
        logic [63:0] cand;
        logic [63:0] quot;
        logic [63:0] power;
        int unsigned k;
        int unsigned i;
        int          b;
        bit          in_range;
        limit = {1'b0, radicand} & VALUE_MASK;
        k     = (degree == '0) ? 1 : int'(degree);
        acc   = '0;
        for (b = ikr_pkg::ROOT_W - 1; b >= 0; b--) begin
            cand     = acc | (64'd1 << b);
            quot     = limit / cand;
            power    = 64'd1;
            in_range = 1'b1;
            for (i = 0; i < k && in_range; i++) begin
                if (power > quot) begin
                    in_range = 1'b0;
                end else begin
                    power = power * cand;
                end
            end
            if (in_range && power <= limit) begin
                acc = cand;
            end
        end
        return acc[ikr_pkg::ROOT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        root_query_t query;
        root_query_t oldest;
        if (!i_rst_n) begin
            root_failures <= 0;
            pending_roots <= 0;
        end else begin
            if (start && !busy) begin
                query.value    = i_value;
                query.exponent = i_exponent;
                query.root     = kth_root_floor(i_value, i_exponent);
                root_queue.push_back(query);
            end
            if (o_valid) begin
                if (root_queue.size() == 0) begin
                    $display("%0t: unexpected root beat: expected none, actual %0d",
                             $time, o_root);
                    root_failures <= root_failures + 1;
                end else begin
                    oldest = root_queue.pop_front();
                    if (o_root !== oldest.root) begin
                        $display("%0t: root of %0d, exponent %0d: expected %0d, actual %0d",
                                 $time, oldest.value, oldest.exponent, oldest.root, o_root);
                        root_failures <= root_failures + 1;
                    end
                end
            end
            pending_roots <= root_queue.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/integer_kth_root_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_kth_root_tb
// Drives value/exponent beats into the k-th root block: a directed set of
// edge values first, then random perfect powers, their neighbours and plain
// random values under varying sender gaps. The checker beside the block
// predicts and compares every root; this module only makes stimulus and
// reports the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_kth_root_tb;

    localparam int VALUE_BITS    = 63;
    // Run cap: room for every item at its slowest, with slack for sender gaps.
    localparam int CYCLE_LIMIT   = 8_000_000;
    // Watch this long after the last root for stray strobes.
    localparam int SETTLE_CYCLES = 6200;

    localparam logic [ikr_pkg::VALUE_W-1:0] VALUE_MAX = '1;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        start      = 1'b0;
    logic [ikr_pkg::VALUE_W-1:0] i_value    = '0;
    logic [ikr_pkg::EXP_W-1:0]   i_exponent = '0;
    logic                        busy;
    logic                        o_valid;
    logic [ikr_pkg::ROOT_W-1:0]  o_root;

    int root_failures;
    int pending_roots;
    int cycle_count = 0;
    int idle_pct    = 0;

    integer_kth_root #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_exponent (i_exponent),
        .o_valid    (o_valid),
        .o_root     (o_root)
    );

    integer_kth_root_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) root_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_exponent    (i_exponent),
        .o_valid       (o_valid),
        .o_root        (o_root),
        .root_failures (root_failures),
        .pending_roots (pending_roots)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one command beat and hold it until the block takes it. Idle
    // cycles go in front with start low; start stays high straight into the
    // next beat when no idle cycle is drawn, so it is never dropped and
    // raised in one step.
    task automatic drive_root_query(
        input logic [ikr_pkg::VALUE_W-1:0] value,
        input logic [ikr_pkg::EXP_W-1:0]   exponent
    );
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_value    <= value;
        i_exponent <= exponent;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Pick one random beat. Two in five beats sit on an exact power or next to one,
    // where the keep/drop decision of the low root bits is tight; the rest
    // are full-width noise, scaled-down values and tiny values.
    task automatic drive_random_query();
        logic [63:0]               raw;
        logic [63:0]               power;
        logic [ikr_pkg::EXP_W-1:0] exponent;
        int unsigned               kind;
        int unsigned               width;
        int unsigned               base;
        int unsigned               i;
        raw      = {$urandom, $urandom};
        exponent = 6'($urandom_range(0, 63));
        kind     = $urandom_range(99);
        if (kind < 40) begin
            // exact power t^k, or one below or above it
            exponent = 6'($urandom_range(2, 12));
            width    = 63 / int'(exponent);
            base     = $urandom_range(1, (32'd1 << width) - 1);
            power    = 64'd1;
            for (i = 0; i < exponent; i++) begin
                power = power * 64'(base);
            end
            raw = power + 64'($urandom_range(0, 2)) - 64'd1;
        end else if (kind < 65) begin
            // full-width value, any exponent
        end else if (kind < 90) begin
            raw = raw >> $urandom_range(0, 62);
        end else begin
            raw = 64'($urandom_range(0, 20));
        end
        drive_root_query(raw[ikr_pkg::VALUE_W-1:0], exponent);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the first gap mix.
        idle_pct = 34;
        // zero and one return themselves for any exponent, out-of-range too
        drive_root_query('0, 6'd1);
        drive_root_query('0, 6'd63);
        drive_root_query('0, 6'd0);
        drive_root_query(63'd1, 6'd63);
        drive_root_query(63'd1, 6'd0);
        drive_root_query(63'd1, 6'd2);
        // exponent one passes the value through, saturating above 32 bits
        drive_root_query(VALUE_MAX, 6'd1);
        drive_root_query(63'hFFFF_FFFF, 6'd1);
        drive_root_query(63'h1_0000_0000, 6'd1);
        // exponent zero behaves as exponent one
        drive_root_query(63'd12345, 6'd0);
        drive_root_query(VALUE_MAX, 6'd0);
        // square roots at the top of the range and on an exact square
        drive_root_query(VALUE_MAX, 6'd2);
        drive_root_query(63'd9223372030926249001, 6'd2);
        drive_root_query(63'd9223372030926249000, 6'd2);
        drive_root_query(63'd16, 6'd2);
        drive_root_query(63'd15, 6'd2);
        drive_root_query(VALUE_MAX, 6'd3);
        // large exponents: anything from 1 up to just below 2^k gives 1
        drive_root_query(VALUE_MAX, 6'd63);
        drive_root_query(63'h4000_0000_0000_0000, 6'd62);
        drive_root_query(63'h3FFF_FFFF_FFFF_FFFF, 6'd62);
        drive_root_query(63'd5, 6'd40);
        drive_root_query(63'd4052555153018976267, 6'd39);
        drive_root_query(63'd4052555153018976266, 6'd39);
        drive_root_query(VALUE_MAX, 6'd32);
        drive_root_query(VALUE_MAX, 6'd31);

        // Random beats in three gap phases.
        repeat (90) drive_random_query();
        idle_pct = 46;
        repeat (90) drive_random_query();
        idle_pct = 0;
        repeat (86) drive_random_query();
        start <= 1'b0;

        // Drain: wait for every root, then watch for strays.
        do @(posedge i_clk); while (pending_roots != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (root_failures == 0 && pending_roots == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
